// ===== hw/rtl/amt_pkg.sv =====
// Package for the adaptive median threshold block.
// Holds window sizing, payload structs, cell entry and control types, and the sort key.
// Used by amt_cell and adaptive_median_threshold.
package amt_pkg;

	localparam int WINDOW_DEPTH = 100;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int DATA_W       = 32;
	localparam int COUNT_OUT_W  = 7;

	localparam logic [DATA_W-1:0] INIT_THRESHOLD_RST = 32'd131072;
	localparam logic [DATA_W-1:0] RECIP_TEN          = 32'hCCCC_CCCD;
	localparam int                RECIP_SHIFT        = 35;

	typedef struct packed {
		logic [DATA_W-1:0] deviation;
		logic              push_req;
	} amt_in_t;

	typedef struct packed {
		logic [DATA_W-1:0]      threshold;
		logic [COUNT_OUT_W-1:0] window_count;
	} amt_out_t;

	typedef struct packed {
		logic              valid;
		logic [CNT_W-1:0]  age;
		logic [DATA_W-1:0] value;
	} amt_entry_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_PUSH,
		OP_SORT,
		OP_LOAD,
		OP_SHIFT
	} amt_op_t;

	typedef struct packed {
		amt_op_t op;
		logic    full;
		logic    is_top;
		logic    pair_lo;
		logic    pair_hi;
	} amt_ctrl_t;

	function automatic logic [DATA_W:0] amt_key(amt_entry_t e);
		return {~e.valid, e.value};
	endfunction

endpackage

// ===== hw/rtl/amt_cell.sv =====
// One cell of the sorted window chain: a deviation with its age and a read tap.
// Swaps with a neighbor in odd-even sort steps and shifts the read chain downward.
// Depends on amt_pkg.
module amt_cell
	import amt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  amt_ctrl_t         ctrl,
	input  logic [DATA_W-1:0] new_value,
	input  amt_entry_t        below,
	input  amt_entry_t        above,
	input  logic [DATA_W-1:0] rd_above,
	output amt_entry_t        entry,
	output logic [DATA_W-1:0] rd
);

	logic              valid_q;
	logic [CNT_W-1:0]  age_q;
	logic [DATA_W-1:0] value_q;
	logic [DATA_W-1:0] rd_q;
	amt_entry_t        nxt;
	logic              swap;

	assign entry = '{valid: valid_q, age: age_q, value: value_q};
	assign rd    = rd_q;

	always_comb begin
		nxt  = entry;
		swap = 1'b0;
		unique case (ctrl.op)
			OP_PUSH: begin
				if (ctrl.full) begin
					if (valid_q && age_q == CNT_W'(WINDOW_DEPTH - 1)) begin
						nxt = '{valid: 1'b1, age: '0, value: new_value};
					end else if (valid_q) begin
						nxt.age = age_q + 1'b1;
					end
				end else if (ctrl.is_top) begin
					nxt = '{valid: 1'b1, age: '0, value: new_value};
				end else if (valid_q) begin
					nxt.age = age_q + 1'b1;
				end
			end
			OP_SORT: begin
				if (ctrl.pair_lo) begin
					swap = amt_key(above) < amt_key(entry);
					if (swap) begin
						nxt = above;
					end
				end else if (ctrl.pair_hi) begin
					swap = amt_key(entry) < amt_key(below);
					if (swap) begin
						nxt = below;
					end
				end
			end
			OP_HOLD, OP_LOAD, OP_SHIFT: begin
				nxt = entry;
			end
			default: begin
				nxt = entry;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
			value_q <= '0;
			rd_q    <= '0;
		end else begin
			valid_q <= nxt.valid;
			age_q   <= nxt.age;
			value_q <= nxt.value;
			if (ctrl.op == OP_LOAD) begin
				rd_q <= value_q;
			end else if (ctrl.op == OP_SHIFT) begin
				rd_q <= rd_above;
			end
		end
	end

endmodule

// ===== hw/rtl/adaptive_median_threshold.sv =====
// A push item passes through the push step, the odd-even sort pass over the cell chain, the
// read-chain load and shift, then the multiply and output steps. An item without a push goes
// straight to the multiply and output steps. One item is in flight at a time; the next is
// taken once the result sits in the output register.
// Reset clears the window (empty), the control state and sets the start threshold to 131072.
// Depends on amt_pkg and amt_cell.
module adaptive_median_threshold
	import amt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  amt_in_t           in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output amt_out_t          out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_SORT,
		ST_LOAD,
		ST_SHIFT,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [DATA_W-1:0] init_q;
	logic [DATA_W-1:0] dev_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [63:0]       prod_q;
	logic [DATA_W+1:0] trip_q;
	logic              out_valid_q;
	amt_out_t          out_q;

	amt_entry_t        ent   [WINDOW_DEPTH];
	logic [DATA_W-1:0] rdv   [WINDOW_DEPTH];
	amt_ctrl_t         ctrl  [WINDOW_DEPTH];
	logic [WINDOW_DEPTH-1:0] valid_vec;

	amt_op_t           op;
	logic              full;
	logic              phase;
	logic [CNT_W-1:0]  half;
	logic [DATA_W-1:0] floor_val;
	logic [DATA_W-1:0] scaled;
	logic [DATA_W-1:0] thr;
	logic              in_xfer;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign full  = (fill_q == CNT_W'(WINDOW_DEPTH));
	assign phase = cnt_q[0];
	assign half  = fill_q >> 1;

	always_comb begin
		unique case (state_q)
			ST_PUSH:  op = OP_PUSH;
			ST_SORT:  op = OP_SORT;
			ST_LOAD:  op = OP_LOAD;
			ST_SHIFT: op = OP_SHIFT;
			default:  op = OP_HOLD;
		endcase
	end

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		amt_entry_t        below_e;
		amt_entry_t        above_e;
		logic [DATA_W-1:0] rd_above;

		if (i == 0) begin : g_bottom
			assign below_e = '0;
		end else begin : g_below
			assign below_e = ent[i-1];
		end

		if (i == WINDOW_DEPTH - 1) begin : g_top
			assign above_e  = '0;
			assign rd_above = '0;
		end else begin : g_above
			assign above_e  = ent[i+1];
			assign rd_above = rdv[i+1];
		end

		always_comb begin
			ctrl[i].op      = op;
			ctrl[i].full    = full;
			ctrl[i].is_top  = (i == WINDOW_DEPTH - 1);
			ctrl[i].pair_lo = (i + 1 < WINDOW_DEPTH) && (phase == 1'(i % 2));
			ctrl[i].pair_hi = (i >= 1) && (phase == 1'((i + 1) % 2));
		end

		assign valid_vec[i] = ent[i].valid;

		amt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[i]),
			.new_value(dev_q),
			.below    (below_e),
			.above    (above_e),
			.rd_above (rd_above),
			.entry    (ent[i]),
			.rd       (rdv[i])
		);
	end

	assign floor_val = DATA_W'(prod_q[63:RECIP_SHIFT]);
	assign scaled    = (|trip_q[DATA_W+1:DATA_W]) ? '1 : trip_q[DATA_W-1:0];

	always_comb begin
		if (fill_q == '0) begin
			thr = init_q;
		end else if (scaled > floor_val) begin
			thr = scaled;
		end else begin
			thr = floor_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			init_q      <= INIT_THRESHOLD_RST;
			dev_q       <= '0;
			fill_q      <= '0;
			cnt_q       <= '0;
			prod_q      <= '0;
			trip_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				init_q <= cfg_data;
			end
			if (out_valid_q && !out_stall && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						dev_q   <= in_data.deviation;
						state_q <= in_data.push_req ? ST_PUSH : ST_MUL;
					end
				end
				ST_PUSH: begin
					if (!full) begin
						fill_q <= fill_q + 1'b1;
					end
					cnt_q   <= '0;
					state_q <= ST_SORT;
				end
				ST_SORT: begin
					if (cnt_q == CNT_W'(WINDOW_DEPTH - 1)) begin
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= (half == '0) ? ST_MUL : ST_SHIFT;
				end
				ST_SHIFT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1'b1 == half) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= 64'(init_q) * 64'(RECIP_TEN);
					trip_q  <= (DATA_W+2)'({rdv[0], 1'b0}) + (DATA_W+2)'(rdv[0]);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q        <= 1'b1;
						out_q.threshold    <= thr;
						out_q.window_count <= COUNT_OUT_W'(fill_q);
						state_q            <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW_DEPTH))
		else $error("fill count beyond window depth");

	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> $countones(valid_vec) == 32'(fill_q))
		else $error("valid cells disagree with fill count");

	a_packed_low: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (valid_vec & (valid_vec + 1'b1)) == '0)
		else $error("valid cells not packed at the bottom of the chain");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("second item taken while one is in flight");

endmodule

// ===== tb/adaptive_median_threshold_tb.sv =====
// Testbench for adaptive_median_threshold: drives deviation items and threshold writes,
// predicts every result from its own sliding-window model and checks each transfer.
// Depends on amt_pkg and the adaptive_median_threshold RTL.
module adaptive_median_threshold_tb;
	import amt_pkg::*;

	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = WINDOW_DEPTH + WINDOW_DEPTH / 2 + 10;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 125;
	localparam int NUM_PHASES    = 6;

	class median_window_scoreboard;
		logic [DATA_W-1:0] window[$];
		logic [DATA_W-1:0] init_threshold;
		amt_out_t          pending_thresholds[$];
		int                errors;

		function new();
			init_threshold = INIT_THRESHOLD_RST;
			errors = 0;
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function amt_out_t apply_item(amt_in_t it);
			logic [DATA_W-1:0] sorted[$];
			logic [63:0]       tripled;
			logic [DATA_W-1:0] scaled;
			logic [DATA_W-1:0] floor_val;
			amt_out_t          r;
			if (it.push_req) begin
				if (window.size() >= WINDOW_DEPTH)
					void'(window.pop_front());
				window = {window, it.deviation};
			end
			r.window_count = COUNT_OUT_W'(window.size() & 'h7f);
			if (window.size() == 0) begin
				r.threshold = init_threshold;
			end else begin
				sorted = window;
				sorted.sort();
				tripled = 64'(sorted[sorted.size() / 2]) * 64'd3;
				scaled = (tripled > 64'hFFFF_FFFF) ? '1 : tripled[DATA_W-1:0];
				floor_val = init_threshold / 32'd10;
				r.threshold = (scaled > floor_val) ? scaled : floor_val;
			end
			return r;
		endfunction

		function void note_input(amt_in_t it);
			pending_thresholds = {pending_thresholds, apply_item(it)};
		endfunction

		task check_result(amt_out_t got);
			amt_out_t exp_r;
			if (pending_thresholds.size() == 0) begin
				report($sformatf("unexpected result thr=%h cnt=%0d", got.threshold,
					got.window_count));
			end else begin
				exp_r = pending_thresholds.pop_front();
				if (got.threshold !== exp_r.threshold)
					report($sformatf("threshold %h, want %h", got.threshold,
						exp_r.threshold));
				if (got.window_count !== exp_r.window_count)
					report($sformatf("window_count %0d, want %0d", got.window_count,
						exp_r.window_count));
			end
		endtask

		function int pending();
			return pending_thresholds.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	amt_in_t           in_data = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	amt_out_t          out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [DATA_W-1:0] cfg_data = '0;

	median_window_scoreboard sb = new();
	bit calm = 1'b0;
	bit long_hold_req = 1'b0;
	int quiet_cycles = 0;

	adaptive_median_threshold i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		int idle_left;
		int hold_left;
		idle_left = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				sb.check_result(out_data);
				idle_left = calm ? 0 : $urandom_range(0, 3);
			end
			if (long_hold_req) begin
				hold_left = LONG_HOLD;
				long_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (idle_left > 0) begin
				idle_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task send_item(input amt_in_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	task wait_drained();
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task write_threshold(input logic [DATA_W-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.init_threshold = value;
	endtask

	function automatic logic [DATA_W-1:0] rand_deviation();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 32'h0003_0000);
			2: return 32'h5555_5553 + $urandom_range(0, 5);
			3: return 32'hFFFF_FFFF - $urandom_range(0, 15);
			4: return $urandom_range(0, 15);
			default: return $urandom_range(32'h0000_1000, 32'h0010_0000);
		endcase
	endfunction

	logic [DATA_W:0] directed_items[18] = '{
		{1'b0, 32'hFFFF_FFFF}, {1'b1, 32'h0000_0000}, {1'b1, 32'hFFFF_FFFF},
		{1'b1, 32'h0000_0001}, {1'b0, 32'h1234_5678}, {1'b1, 32'h5555_5555},
		{1'b1, 32'h5555_5556}, {1'b1, 32'h0000_1111}, {1'b1, 32'h0000_1110},
		{1'b1, 32'h0000_1110}, {1'b1, 32'h0000_1110}, {1'b1, 32'h0000_1110},
		{1'b1, 32'h0000_1110}, {1'b1, 32'h0001_0000}, {1'b0, 32'h0000_0000},
		{1'b1, 32'hAAAA_AAAA}, {1'b1, 32'h0000_FFFF}, {1'b1, 32'h8000_0000}
	};

	logic [DATA_W-1:0] threshold_settings[NUM_PHASES] = '{
		32'd0, 32'hFFFF_FFFF, 32'd10, 32'd9, 32'h0000_0000, 32'd131072
	};

	initial begin
		amt_in_t it;
		threshold_settings[4] = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_items[i]) begin
			it.push_req = directed_items[i][DATA_W];
			it.deviation = directed_items[i][DATA_W-1:0];
			send_item(it);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_threshold(threshold_settings[p]);
			calm = (p == 3);
			if (p == 2)
				long_hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				it.deviation = rand_deviation();
				it.push_req = ($urandom_range(0, 3) != 0);
				send_item(it);
			end
		end
		in_valid <= 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
